/* hw/rtl/sprvd_pkg.sv */
// ----------------------------------------------------------------------------
// sprvd_pkg: shared types and codes for packet reassembly and varint decode
// Holds the field widths, result kind codes and packet status codes.
// ----------------------------------------------------------------------------
package sprvd_pkg;

  localparam int SEQ_W   = 7;
  localparam int LEN_W   = 8;
  localparam int BYTE_W  = 8;
  localparam int VALUE_W = 28;
  localparam int DIGIT_W = 7;

  typedef logic [1:0] status_t;

  localparam status_t ST_SUCCESS  = 2'd0;
  localparam status_t ST_FINAL    = 2'd1;
  localparam status_t ST_MISSED   = 2'd2;
  localparam status_t ST_OVERFLOW = 2'd3;

  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_DECODE = 1'b1;

  localparam logic RK_STATUS = 1'b0;
  localparam logic RK_VARINT = 1'b1;

endpackage

/* hw/rtl/sprvd_byte_ram.sv */
// ----------------------------------------------------------------------------
// sprvd_byte_ram: payload byte store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sprvd_byte_ram #(
  parameter int DEPTH = 512,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [sprvd_pkg::BYTE_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [sprvd_pkg::BYTE_W-1:0] rd_data
);

  logic [sprvd_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/seq_packet_reassembly_varint_decode.sv */
// ----------------------------------------------------------------------------
// seq_packet_reassembly_varint_decode: packet reassembly with varint reader
// Collects sequenced packet payloads into a byte store and decodes
// little-endian base-128 varints from the last final packet on request.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  input    | in_valid / in_ready  | kind, byte_value, first_byte, last_byte,
//           |                      | packet_length
//  output   | out_valid / out_ready| result_kind, status, value, at_end,
//           |                      | malformed
//
// a packet byte's header checks, store write and status are settled in the
// transfer cycle itself
// a decode request passes S_FETCH and S_ACC for each stored byte read (up to
// MAX_VARINT_BYTES), with a last S_FETCH when the stored bytes run out first,
// then S_DONE: each byte is read on the store read port in S_FETCH and merged
// by the shared shift-or accumulator in S_ACC
// rst is synchronous; the byte store is not cleared, only ever read below
// the read end armed from the fill index
// a pending result blocks new input until it is taken (or taken that cycle)
module seq_packet_reassembly_varint_decode #(
  parameter int BUFFER_BYTES     = 512,
  parameter int MAX_VARINT_BYTES = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          kind,
  input  logic [sprvd_pkg::BYTE_W-1:0]  byte_value,
  input  logic                          first_byte,
  input  logic                          last_byte,
  input  logic [sprvd_pkg::LEN_W-1:0]   packet_length,
  // output channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          result_kind,
  output sprvd_pkg::status_t            status,
  output logic [sprvd_pkg::VALUE_W-1:0] value,
  output logic                          at_end,
  output logic                          malformed
);

  // address width of the store, sum width for the overflow check
  localparam int AW  = $clog2(BUFFER_BYTES);
  localparam int SW  = ((AW > sprvd_pkg::LEN_W) ? AW : sprvd_pkg::LEN_W) + 1;
  // varint byte counter and digit shift amount
  localparam int CW  = $clog2(MAX_VARINT_BYTES + 1);
  localparam int SHW = $clog2(sprvd_pkg::DIGIT_W * MAX_VARINT_BYTES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_ACC,
    S_DONE
  } state_t;

  state_t state;

  // packet side state
  logic [sprvd_pkg::SEQ_W-1:0] last_seq;
  logic [AW-1:0]               fill;
  sprvd_pkg::status_t          pstat;
  logic                        wen;

  // reader state
  logic [AW-1:0]                rd_cursor;
  logic [AW-1:0]                rd_end;
  logic [sprvd_pkg::VALUE_W-1:0] acc;
  logic [CW-1:0]                cnt;
  logic [SHW-1:0]               shift;
  logic                         done;
  logic                         bad;

  // next values for the packet side
  logic [sprvd_pkg::SEQ_W-1:0] last_seq_next;
  logic [AW-1:0]               fill_next;
  sprvd_pkg::status_t          pstat_next;
  logic                        wen_next;
  logic                        st_wr;
  logic                        arm;

  logic [sprvd_pkg::SEQ_W-1:0] seq;
  logic                        seq_ok;
  logic [AW-1:0]               fill_base;
  logic [SW-1:0]               room_sum;

  logic                        out_free;
  logic                        in_xfer;
  logic                        pkt_xfer;
  logic                        res_load;
  logic                        rd_en;
  logic [sprvd_pkg::BYTE_W-1:0] rd_data;
  logic [sprvd_pkg::VALUE_W-1:0] digit;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign in_xfer  = in_valid && in_ready;
  assign pkt_xfer = in_xfer && (kind == sprvd_pkg::KIND_PACKET);

  // a new result is loaded by a closing packet byte or a finished decode
  assign res_load = (pkt_xfer && last_byte) || ((state == S_DONE) && out_free);

  // header checks: sequence 0 restarts, otherwise strictly one more, no wrap
  assign seq       = byte_value[sprvd_pkg::SEQ_W-1:0];
  assign seq_ok    = (seq == '0) ||
                     ({1'b0, seq} == ({1'b0, last_seq} + 8'd1));
  assign fill_base = (seq == '0) ? '0 : fill;
  assign room_sum  = SW'(fill_base) + SW'(packet_length) - SW'(1);

  always_comb begin
    last_seq_next = last_seq;
    fill_next     = fill;
    pstat_next    = pstat;
    wen_next      = wen;
    st_wr         = 1'b0;
    if (first_byte) begin
      if (!seq_ok) begin
        pstat_next = sprvd_pkg::ST_MISSED;
        wen_next   = 1'b0;
      end else begin
        last_seq_next = seq;
        fill_next     = fill_base;
        if ((packet_length == '0) || (room_sum >= SW'(BUFFER_BYTES))) begin
          pstat_next = sprvd_pkg::ST_OVERFLOW;
          wen_next   = 1'b0;
        end else begin
          pstat_next = byte_value[sprvd_pkg::BYTE_W-1] ? sprvd_pkg::ST_FINAL
                                                       : sprvd_pkg::ST_SUCCESS;
          wen_next   = 1'b1;
        end
      end
    end else if (wen && (fill < AW'(BUFFER_BYTES - 1))) begin
      st_wr     = 1'b1;
      fill_next = fill + AW'(1);
    end
    // an accepted final packet arms the reader when it closes
    arm = last_byte && wen_next && (pstat_next == sprvd_pkg::ST_FINAL);
    if (last_byte) begin
      wen_next = 1'b0;
    end
  end

  // reader: one store read, then one shift-or step per varint byte
  assign rd_en = (state == S_FETCH) && (rd_cursor < rd_end);
  assign digit = {{(sprvd_pkg::VALUE_W - sprvd_pkg::DIGIT_W){1'b0}},
                  rd_data[sprvd_pkg::DIGIT_W-1:0]} << shift;

  sprvd_byte_ram #(
    .DEPTH (BUFFER_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (pkt_xfer && st_wr),
    .wr_addr (fill),
    .wr_data (byte_value),
    .rd_en   (rd_en),
    .rd_addr (rd_cursor),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      last_seq  <= '0;
      fill      <= '0;
      pstat     <= sprvd_pkg::ST_SUCCESS;
      wen       <= 1'b0;
      rd_cursor <= '0;
      rd_end    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pkt_xfer) begin
            last_seq <= last_seq_next;
            fill     <= fill_next;
            pstat    <= pstat_next;
            wen      <= wen_next;
            if (arm) begin
              rd_cursor <= '0;
              rd_end    <= fill_next;
            end
            if (last_byte) begin
              result_kind <= sprvd_pkg::RK_STATUS;
              status      <= pstat_next;
              value       <= '0;
              at_end      <= 1'b0;
              malformed   <= 1'b0;
            end
          end else if (in_xfer) begin
            // decode request
            acc   <= '0;
            cnt   <= '0;
            shift <= '0;
            done  <= 1'b0;
            bad   <= 1'b0;
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          if (rd_cursor >= rd_end) begin
            state <= S_DONE;
          end else begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          acc       <= acc | digit;
          rd_cursor <= rd_cursor + AW'(1);
          if (!rd_data[sprvd_pkg::BYTE_W-1]) begin
            done  <= 1'b1;
            state <= S_DONE;
          end else if (cnt == CW'(MAX_VARINT_BYTES - 1)) begin
            bad   <= 1'b1;
            state <= S_DONE;
          end else begin
            cnt   <= cnt + CW'(1);
            shift <= shift + SHW'(sprvd_pkg::DIGIT_W);
            state <= S_FETCH;
          end
        end
        S_DONE: begin
          if (out_free) begin
            result_kind <= sprvd_pkg::RK_VARINT;
            status      <= sprvd_pkg::ST_SUCCESS;
            value       <= done ? acc : '0;
            at_end      <= (rd_cursor >= rd_end);
            malformed   <= bad;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // the reader never runs past the armed end and the fill index stays in range
  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    (rd_cursor <= rd_end) && ({1'b0, fill} < (AW+1)'(BUFFER_BYTES)))
    else $error("read cursor past end or fill index out of range");

  // a closing packet byte yields a status result on the next cycle
  a_status_on_last: assert property (@(posedge clk) disable iff (rst)
    pkt_xfer && last_byte |=> out_valid && (result_kind == sprvd_pkg::RK_STATUS))
    else $error("no status result after last packet byte");

  // a malformed varint never carries a value
  a_malformed_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && malformed |-> (value == '0) &&
    (result_kind == sprvd_pkg::RK_VARINT))
    else $error("malformed varint with nonzero value");

  // no new transfer is taken while a decode is in flight
  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready)
    else $error("input ready during decode");

endmodule

/* dv/seq_packet_reassembly_varint_decode_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// seq_packet_reassembly_varint_decode_tb: self-checking bench for reassembly
// Streams sequenced packets and decode requests through the input channel and
// checks every packet status and decoded varint against an in-bench model of
// the sequence check, the byte store and the base-128 reader.
// ----------------------------------------------------------------------------
module seq_packet_reassembly_varint_decode_tb;

  localparam int BUF_BYTES  = 512;
  localparam int VARINT_MAX = 4;

  // one input transfer; drain marks a pause until all results are back
  typedef struct packed {
    logic                          kind;
    logic [sprvd_pkg::BYTE_W-1:0]  byte_value;
    logic                          first_byte;
    logic                          last_byte;
    logic [sprvd_pkg::LEN_W-1:0]   packet_length;
    logic                          drain;
  } pkt_item_t;

  typedef struct packed {
    logic                          result_kind;
    sprvd_pkg::status_t            status;
    logic [sprvd_pkg::VALUE_W-1:0] value;
    logic                          at_end;
    logic                          malformed;
  } decode_result_t;

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          kind = sprvd_pkg::KIND_PACKET;
  logic [sprvd_pkg::BYTE_W-1:0]  byte_value = '0;
  logic                          first_byte = 1'b0;
  logic                          last_byte = 1'b0;
  logic [sprvd_pkg::LEN_W-1:0]   packet_length = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          result_kind;
  sprvd_pkg::status_t            status;
  logic [sprvd_pkg::VALUE_W-1:0] value;
  logic                          at_end;
  logic                          malformed;

  seq_packet_reassembly_varint_decode #(
    .BUFFER_BYTES     (BUF_BYTES),
    .MAX_VARINT_BYTES (VARINT_MAX)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .byte_value    (byte_value),
    .first_byte    (first_byte),
    .last_byte     (last_byte),
    .packet_length (packet_length),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_kind   (result_kind),
    .status        (status),
    .value         (value),
    .at_end        (at_end),
    .malformed     (malformed)
  );

  // stimulus and scoreboard storage
  pkt_item_t       byte_feed[$];
  decode_result_t  due_results[$];
  logic [7:0]      digit_feed[$];
  pkt_item_t       cur_item;

  // model state of the reassembly and the reader
  logic [sprvd_pkg::SEQ_W-1:0] seq_last;
  int                          fill_pos;
  sprvd_pkg::status_t          pkt_status;
  bit                          wr_open;
  int                          rd_cursor;
  int                          rd_end;
  logic [7:0]                  store_mem [BUF_BYTES];

  // handshake bookkeeping between the rising and falling edge blocks
  bit  in_took, out_took;
  bit  in_burst, out_burst;
  int  in_gap, out_stall;

  int  errors, fed, n_in, n_decodes, n_drains;
  int  status_seen [4];
  int  n_varints, n_malformed, n_at_end;

  // --------------------------------------------------------------------------
  // model: one accepted transfer in, zero or one result queued
  // --------------------------------------------------------------------------
  task automatic reassemble_step(input pkt_item_t it);
    decode_result_t                r;
    logic [sprvd_pkg::SEQ_W-1:0]   seq;
    logic [7:0]                    b;
    logic [sprvd_pkg::VALUE_W-1:0] acc;
    bit                            done;
    int                            i;
    r = '0;
    if (it.kind == sprvd_pkg::KIND_PACKET) begin
      if (it.first_byte) begin
        seq = it.byte_value[sprvd_pkg::SEQ_W-1:0];
        // nonzero sequence must follow the last one, 127 has no successor
        if (seq != 0 && int'(seq) != int'(seq_last) + 1) begin
          pkt_status = sprvd_pkg::ST_MISSED;
          wr_open = 1'b0;
        end else begin
          if (seq == 0) fill_pos = 0;
          seq_last = seq;
          // zero length or payload that would reach the buffer size
          if (it.packet_length == 0 ||
              fill_pos + int'(it.packet_length) - 1 >= BUF_BYTES) begin
            pkt_status = sprvd_pkg::ST_OVERFLOW;
            wr_open = 1'b0;
          end else begin
            pkt_status = it.byte_value[7] ? sprvd_pkg::ST_FINAL : sprvd_pkg::ST_SUCCESS;
            wr_open = 1'b1;
          end
        end
      end else if (wr_open && fill_pos < BUF_BYTES - 1) begin
        store_mem[fill_pos] = it.byte_value;
        fill_pos++;
      end
      if (it.last_byte) begin
        // only an open final packet arms the reader
        if (wr_open && pkt_status == sprvd_pkg::ST_FINAL) begin
          rd_cursor = 0;
          rd_end = fill_pos;
        end
        wr_open = 1'b0;
        r.result_kind = sprvd_pkg::RK_STATUS;
        r.status = pkt_status;
        due_results.push_back(r);
      end
    end else begin
      acc = '0;
      done = 1'b0;
      i = 0;
      while (i < VARINT_MAX && !done && rd_cursor < rd_end) begin
        b = store_mem[rd_cursor];
        rd_cursor++;
        acc = acc | (sprvd_pkg::VALUE_W'(b[6:0]) << (sprvd_pkg::DIGIT_W * i));
        if (!b[7]) done = 1'b1;
        i++;
      end
      r.result_kind = sprvd_pkg::RK_VARINT;
      r.value = done ? acc : '0;
      r.malformed = !done && i == VARINT_MAX;
      r.at_end = rd_cursor >= rd_end;
      due_results.push_back(r);
    end
  endtask

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, fname, want, got);
      errors++;
    end
  endtask

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic feed(input logic k, input logic [7:0] bv, input logic f,
                      input logic l, input logic [7:0] len);
    pkt_item_t it;
    it = '{kind: k, byte_value: bv, first_byte: f, last_byte: l,
           packet_length: len, drain: 1'b0};
    byte_feed.push_back(it);
    fed++;
  endtask

  task automatic hold_until_drained();
    pkt_item_t it;
    it = '0;
    it.drain = 1'b1;
    byte_feed.push_back(it);
  endtask

  task automatic ask_decode(input int n);
    int j;
    for (j = 0; j < n; j++)
      feed(sprvd_pkg::KIND_DECODE, 8'($urandom), 1'($urandom), 1'($urandom),
           8'($urandom));
  endtask

  // payload content is a running stream of encoded varints, so reads
  // mostly land on digit boundaries
  function automatic logic [7:0] next_store_byte();
    int pick, n, k;
    if (digit_feed.size() == 0) begin
      pick = $urandom_range(0, 11);
      if (pick == 0) begin
        // four continuation bytes in a row
        for (k = 0; k < VARINT_MAX; k++)
          digit_feed.push_back({1'b1, 7'($urandom)});
      end else if (pick == 1) begin
        digit_feed.push_back(8'hFF);
        digit_feed.push_back(8'hFF);
        digit_feed.push_back(8'hFF);
        digit_feed.push_back(8'h7F);
      end else if (pick == 2) begin
        digit_feed.push_back(8'h00);
      end else begin
        n = $urandom_range(1, VARINT_MAX);
        for (k = 0; k < n; k++)
          digit_feed.push_back({k != n - 1, 7'($urandom)});
      end
    end
    return digit_feed.pop_front();
  endfunction

  // header then nbytes payload; closes puts last_byte on the final item
  task automatic send_packet(input int seq, input bit fin, input int len,
                             input int nbytes, input bit closes);
    int j;
    feed(sprvd_pkg::KIND_PACKET, {fin, 7'(seq)}, 1'b1, closes && nbytes == 0, 8'(len));
    for (j = 0; j < nbytes; j++)
      feed(sprvd_pkg::KIND_PACKET, next_store_byte(), 1'b0, closes && j == nbytes - 1,
           8'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // rising edge: model the accepted input transfer, then check the output
  // transfer; the model goes first so a same-edge result finds its entry
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    decode_result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        reassemble_step(cur_item);
        in_took = 1'b1;
        n_in++;
        if (cur_item.kind == sprvd_pkg::KIND_DECODE) n_decodes++;
      end
      if (out_valid && out_ready) begin
        out_took = 1'b1;
        if (due_results.size() == 0) begin
          $display("%0t: result with nothing expected, actual kind %0d status %0d",
                   $time, result_kind, status);
          $display("%0t: unexpected result value 0x%0h", $time, value);
          errors++;
        end else begin
          want = due_results.pop_front();
          check_field("result_kind", want.result_kind, result_kind);
          check_field("status", want.status, status);
          check_field("value", want.value, value);
          check_field("at_end", want.at_end, at_end);
          check_field("malformed", want.malformed, malformed);
          if (want.result_kind == sprvd_pkg::RK_STATUS) begin
            status_seen[want.status]++;
          end else begin
            n_varints++;
            if (want.malformed) n_malformed++;
            if (want.at_end) n_at_end++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // falling edge driver: holds valid and payload until the transfer, then
  // waits its drawn gap before presenting the next item
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : driver
    bit nv;
    if (!rst && !(in_valid && !in_took)) begin
      in_took = 1'b0;
      nv = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
      end else if (byte_feed.size() > 0 && byte_feed[0].drain) begin
        // sender pause: nothing new until every result is back
        if (due_results.size() == 0) begin
          void'(byte_feed.pop_front());
          n_drains++;
        end
      end else if (byte_feed.size() > 0) begin
        cur_item = byte_feed.pop_front();
        kind <= cur_item.kind;
        byte_value <= cur_item.byte_value;
        first_byte <= cur_item.first_byte;
        last_byte <= cur_item.last_byte;
        packet_length <= cur_item.packet_length;
        nv = 1'b1;
        if ($urandom_range(0, 63) == 0) in_burst = !in_burst;
        in_gap = in_burst ? 0 : $urandom_range(0, 15);
      end
      in_valid <= nv;
    end
  end

  // falling edge receiver: stalls ready for a drawn count after each transfer
  always @(negedge clk) begin : receiver
    if (out_took) begin
      out_took = 1'b0;
      if ($urandom_range(0, 63) == 0) out_burst = !out_burst;
      out_stall = out_burst ? 0 : $urandom_range(0, 15);
    end
    if (out_stall > 0) begin
      out_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int  r, sub, seq, len, npk, k, s, bad, gen_seq, directed_end;
    bit  restart, fin, did_fill, did_chain;

    seq_last = '0;
    fill_pos = 0;
    pkt_status = sprvd_pkg::ST_SUCCESS;
    wr_open = 1'b0;
    rd_cursor = 0;
    rd_end = 0;
    foreach (store_mem[i]) store_mem[i] = '0;

    // directed: reader idle after reset, header that is also the last byte
    ask_decode(1);
    send_packet(0, 1'b1, 1, 0, 1'b1);
    // one-byte digit, widest value, then a varint cut off by the fill end
    feed(sprvd_pkg::KIND_PACKET, 8'h81, 1'b1, 1'b0, 8'd7);
    feed(sprvd_pkg::KIND_PACKET, 8'h7F, 1'b0, 1'b0, 8'h00);
    feed(sprvd_pkg::KIND_PACKET, 8'hFF, 1'b0, 1'b0, 8'hFF);
    feed(sprvd_pkg::KIND_PACKET, 8'hFF, 1'b0, 1'b0, 8'h00);
    feed(sprvd_pkg::KIND_PACKET, 8'hFF, 1'b0, 1'b0, 8'hFF);
    feed(sprvd_pkg::KIND_PACKET, 8'h7F, 1'b0, 1'b0, 8'h00);
    feed(sprvd_pkg::KIND_PACKET, 8'h81, 1'b0, 1'b1, 8'hFF);
    ask_decode(4);
    // four continuation bytes give a malformed result
    feed(sprvd_pkg::KIND_PACKET, 8'h82, 1'b1, 1'b0, 8'd5);
    feed(sprvd_pkg::KIND_PACKET, 8'h80, 1'b0, 1'b0, 8'h00);
    feed(sprvd_pkg::KIND_PACKET, 8'h80, 1'b0, 1'b0, 8'h00);
    feed(sprvd_pkg::KIND_PACKET, 8'h80, 1'b0, 1'b0, 8'h00);
    feed(sprvd_pkg::KIND_PACKET, 8'h80, 1'b0, 1'b1, 8'h00);
    ask_decode(4);
    // skipped sequence, zero length, stray last byte
    feed(sprvd_pkg::KIND_PACKET, 8'h05, 1'b1, 1'b1, 8'd1);
    feed(sprvd_pkg::KIND_PACKET, 8'h03, 1'b1, 1'b1, 8'd0);
    feed(sprvd_pkg::KIND_PACKET, 8'h5A, 1'b0, 1'b1, 8'd9);
    // a second header while a packet is still open
    feed(sprvd_pkg::KIND_PACKET, 8'h04, 1'b1, 1'b0, 8'd3);
    feed(sprvd_pkg::KIND_PACKET, 8'h85, 1'b1, 1'b0, 8'd2);
    feed(sprvd_pkg::KIND_PACKET, 8'h05, 1'b0, 1'b1, 8'h00);
    ask_decode(1);
    hold_until_drained();
    directed_end = fed;

    gen_seq = 5;
    restart = 1'b1;
    did_fill = 1'b0;
    did_chain = 1'b0;
    while (fed < directed_end + 1600) begin
      if (!did_fill && fed > directed_end + 300) begin
        // fill the store to its top, pad past it, then overflow
        did_fill = 1'b1;
        digit_feed.delete();
        send_packet(0, 1'b0, 255, 254, 1'b1);
        send_packet(1, 1'b0, 255, 254, 1'b1);
        send_packet(2, 1'b1, 4, 10, 1'b1);
        send_packet(3, 1'b0, 2, 1, 1'b1);
        ask_decode(40);
        gen_seq = 3;
        restart = 1'b1;
      end else if (!did_chain && fed > directed_end + 900) begin
        // walk the sequence up to 127, then try to go past it
        did_chain = 1'b1;
        digit_feed.delete();
        send_packet(0, 1'b0, 1, 0, 1'b1);
        for (s = 1; s < 128; s++) begin
          len = $urandom_range(1, 3);
          send_packet(s, s == 127, len, len - 1, 1'b1);
        end
        ask_decode(2);
        send_packet(1, 1'b0, 1, 0, 1'b1);
        hold_until_drained();
        restart = 1'b1;
      end else begin
        r = $urandom_range(0, 19);
        if (r < 12) begin
          // well-formed run of packets, decodes after a final one
          seq = (restart || gen_seq == 127 || $urandom_range(0, 2) == 0) ?
                0 : gen_seq + 1;
          restart = 1'b0;
          if (seq == 0) digit_feed.delete();
          npk = $urandom_range(1, 4);
          fin = 1'b0;
          for (k = 0; k < npk; k++) begin
            fin = (k == npk - 1) && ($urandom_range(0, 1) == 1);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) :
                  $urandom_range(1, 12);
            send_packet(seq, fin, len, len - 1, 1'b1);
            gen_seq = seq;
            seq = (seq == 127) ? 0 : seq + 1;
          end
          if (fin) ask_decode($urandom_range(1, 8));
        end else if (r < 15) begin
          ask_decode($urandom_range(1, 3));
        end else if (r < 17) begin
          // noise: every field random
          for (k = 0; k < int'($urandom_range(1, 4)); k++)
            feed(1'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                 8'($urandom));
          restart = 1'b1;
        end else begin
          sub = $urandom_range(0, 3);
          seq = (restart || gen_seq == 127) ? 0 : gen_seq + 1;
          len = $urandom_range(1, 8);
          if (sub == 0) begin
            // out of order sequence number
            bad = gen_seq + 2;
            if (bad > 127) bad = bad - 127;
            send_packet(bad, 1'($urandom), len, len - 1, 1'b1);
          end else if (sub == 1) begin
            // payload with no header ahead of it
            for (k = 0; k < len; k++)
              feed(sprvd_pkg::KIND_PACKET, 8'($urandom), 1'b0, k == len - 1,
                   8'($urandom));
          end else if (sub == 2) begin
            // more payload than the header announced
            send_packet(seq, 1'($urandom), len, len - 1 + $urandom_range(1, 6), 1'b1);
            gen_seq = seq;
            restart = 1'b0;
          end else begin
            // packet left open, the next header restarts
            len = $urandom_range(3, 12);
            send_packet(seq, 1'($urandom), len, $urandom_range(0, len - 2), 1'b0);
            gen_seq = seq;
            restart = 1'b0;
          end
        end
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (byte_feed.size() != 0 || in_valid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);

    $display("run: %0d input transfers (%0d decode requests), %0d sender pauses",
             n_in, n_decodes, n_drains);
    $display("run: status ok/final/missed/overflow %0d/%0d/%0d/%0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    $display("run: %0d varints (%0d malformed, %0d at end)",
             n_varints, n_malformed, n_at_end);
    if (errors == 0 && due_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #10_000_000;
    $display("timeout: %0d results still expected", due_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
